// ----- hdl/fvsp_pkg.sv -----
package fvsp_pkg;

    // Transaction codes, shared by the action field and the queue entries
    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_DMA  = 3'd1,
        OP_LEN  = 3'd2,
        OP_PER  = 3'd3,
        OP_VOL  = 3'd4,
        OP_PTR  = 3'd5,
        OP_MEM  = 3'd6,
        OP_NONE = 3'd7
    } op_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_APPLY,
        ST_DONE
    } state_t;

    // One classified transaction in the queue
    typedef struct packed {
        op_t         op;
        logic [1:0]  voice;
        logic [15:0] data;
        logic [15:0] addr;
    } item_t;

    localparam logic [16:0] MIN_PERIOD  = 17'd113;
    localparam logic [16:0] ZERO_PERIOD = 17'd65536;
    localparam logic [6:0]  MAX_VOLUME  = 7'd64;
    localparam logic [31:0] RATIO_RESET = 32'd1239768088;
    localparam int          DMA_SET_BIT = 15;
    localparam int          DIV_STEPS   = 40;

    // Period 0 means 65536; short periods are held at the minimum
    function automatic logic [16:0] period_clamp(input logic [15:0] d);
        logic [16:0] p;
        p = {1'b0, d};
        if (d == 16'd0)
            p = ZERO_PERIOD;
        else if (p < MIN_PERIOD)
            p = MIN_PERIOD;
        return p;
    endfunction

    // Volume keeps 7 bits and tops out at 64
    function automatic logic [15:0] volume_clamp(input logic [15:0] d);
        logic [6:0] v;
        v = d[6:0];
        if (v > MAX_VOLUME)
            v = MAX_VOLUME;
        return {9'd0, v};
    endfunction

endpackage

// ----- hdl/four_voice_sample_dma_player.sv -----
// Channel   Handshake               Payload
// in        in_valid / in_ready     action, voice, data, sample_address
// out       out_valid / out_ready   left_mix, right_mix, active_mask
// cfg       cfg_valid / cfg_ready   cfg_data (delta ratio)
//
// A front queue of four transactions takes register, DMA and memory writes; the back end
// applies each as it pops it. A tick visits every voice in turn, through setup and apply
// for an active voice and setup only for a stopped one, then done; it is paced by the one
// shared sample memory read port. A period write runs in the bit-serial divider.
// Reset clears all voice state; sample memory is not cleared. Output register
// stalls only the tick sequencer; the front queue keeps accepting until it is full.
module four_voice_sample_dma_player
    import fvsp_pkg::*;
#(
    parameter int VOICE_COUNT   = 4,
    parameter int MEM_ADDR_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic [1:0]         voice,
    input  logic [15:0]        data,
    input  logic [15:0]        sample_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [14:0] left_mix,
    output logic signed [14:0] right_mix,
    output logic [3:0]         active_mask,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    logic [31:0] ratio_reg;
    logic        q_valid;
    logic        q_ready;
    item_t       q_item;

    // Ratio register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ratio_reg <= RATIO_RESET;
        else if (cfg_valid && cfg_ready)
            ratio_reg <= cfg_data;
    end

    fvsp_front #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .voice          (voice),
        .data           (data),
        .sample_address (sample_address),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item)
    );

    fvsp_back #(
        .VOICE_COUNT   (VOICE_COUNT),
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ratio       (ratio_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_mix    (left_mix),
        .right_mix   (right_mix),
        .active_mask (active_mask)
    );

`ifndef NO_ASSERTIONS
    // A new result only follows a busy back end
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_ready))
        else $error("result without tick sequence");

    // No mask bit for voices that do not exist
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (({28'd0, active_mask} >> VOICE_COUNT) == 32'd0))
        else $error("mask bit beyond voice count");

    // Popping a queued tick always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && q_item.op == OP_TICK) |=> !q_ready)
        else $error("tick popped without sequencing");
`endif

endmodule

// ----- hdl/fvsp_front.sv -----
module fvsp_front
    import fvsp_pkg::*;
#(
    parameter int VOICE_COUNT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [1:0]  voice,
    input  logic [15:0] data,
    input  logic [15:0] sample_address,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    localparam int DEPTH = 4;

    item_t       fifo_reg [DEPTH];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;
    logic        push;
    logic        pop;
    logic        keep;
    item_t       entry;

    // Classify: drop unknown actions and writes to voices that do not exist; clamp volumes
    always_comb
    begin
        entry.op    = op_t'(action);
        entry.voice = voice;
        entry.data  = data;
        entry.addr  = sample_address;
        keep        = 1'b1;
        case (op_t'(action))
            OP_TICK, OP_DMA, OP_MEM: keep = 1'b1;
            OP_LEN, OP_PER, OP_PTR:  keep = (32'(voice) < VOICE_COUNT);
            OP_VOL:
            begin
                keep       = (32'(voice) < VOICE_COUNT);
                entry.data = volume_clamp(data);
            end
            default:                 keep = 1'b0;
        endcase
    end

    assign in_ready = (count_reg != 3'(DEPTH));
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 3'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = fifo_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= entry;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            if (push && !pop)
                count_reg <= count_reg + 3'd1;
            else if (pop && !push)
                count_reg <= count_reg - 3'd1;
        end
    end

endmodule

// ----- hdl/fvsp_divider.sv -----
module fvsp_divider
    import fvsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [39:0] quo_reg;
    logic [16:0] rem_reg;
    logic [16:0] div_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [17:0] trial;
    logic        fits;

    // One quotient bit per cycle, restoring
    assign trial    = {rem_reg, quo_reg[39]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign done     = busy_reg && (cnt_reg == 6'd0);
    assign quotient = (quo_reg[39:32] != 8'd0) ? 32'hFFFF_FFFF : quo_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(DIV_STEPS);
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            cnt_reg <= cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            rem_reg <= fits ? 17'(trial - {1'b0, div_reg}) : trial[16:0];
            quo_reg <= {quo_reg[38:0], fits};
        end
    end

endmodule

// ----- hdl/fvsp_back.sv -----
module fvsp_back
    import fvsp_pkg::*;
#(
    parameter int VOICE_COUNT   = 4,
    parameter int MEM_ADDR_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        ratio,
    input  logic               q_valid,
    output logic               q_ready,
    input  item_t              q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [14:0] left_mix,
    output logic signed [14:0] right_mix,
    output logic [3:0]         active_mask
);

    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int AW = MEM_ADDR_BITS;

    // Sample memory
    logic [15:0] mem [2**AW];
    logic [15:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic        mem_we;

    // Voice state
    logic          active_reg   [VOICE_COUNT];
    logic          pvalid_reg   [VOICE_COUNT];
    logic          fvalid_reg   [VOICE_COUNT];
    logic [AW-1:0] sptr_reg     [VOICE_COUNT];
    logic [AW-1:0] fptr_reg     [VOICE_COUNT];
    logic [15:0]   slen_reg     [VOICE_COUNT];
    logic [15:0]   lenleft_reg  [VOICE_COUNT];
    logic [1:0]    bytes_reg    [VOICE_COUNT];
    logic          started_reg  [VOICE_COUNT];
    logic          pend_reg     [VOICE_COUNT];
    logic [15:0]   word_reg     [VOICE_COUNT];
    logic signed [13:0] cur_reg [VOICE_COUNT];
    logic [6:0]    vol_reg      [VOICE_COUNT];
    logic [31:0]   sstep_reg    [VOICE_COUNT];
    logic [31:0]   step_reg     [VOICE_COUNT];
    logic [31:0]   phase_reg    [VOICE_COUNT];

    // Sequencer
    state_t  state_reg, state_next;
    item_t   item_reg;
    logic [VW-1:0] vcnt_reg, vcnt_next;
    logic    do_fetch_reg;
    logic    need_word_reg;
    logic    word_ok_reg;
    logic signed [17:0] left_acc_reg;
    logic signed [17:0] right_acc_reg;
    logic    out_valid_reg;
    logic signed [14:0] left_out_reg;
    logic signed [14:0] right_out_reg;
    logic [3:0] mask_out_reg;

    logic    pop;
    logic    last_voice;
    logic    div_start;
    logic    div_done;
    logic [31:0] div_q;

    // Per-voice working values
    logic          v_act;
    logic          v_need;
    logic [15:0]   v_len_dec;
    logic          v_reload;
    logic [AW-1:0] v_ptr;
    logic          v_ok;
    logic [15:0]   v_word;
    logic signed [15:0] v_prod;
    logic signed [13:0] v_sample;
    logic [32:0]   v_phase;
    logic [1:0]    v_side;
    logic [3:0]    mask_now;

    fvsp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({ratio, 8'd0}),
        .divisor  (period_clamp(q_item.data)),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_ready    = (state_reg == ST_IDLE);
    assign pop        = q_valid && q_ready;
    assign div_start  = pop && (q_item.op == OP_PER);
    assign last_voice = (vcnt_reg == VW'(VOICE_COUNT - 1));

    // Current voice: fetch decision and memory address
    always_comb
    begin
        v_act     = active_reg[vcnt_reg];
        v_need    = pend_reg[vcnt_reg] && (bytes_reg[vcnt_reg] == 2'd0);
        v_len_dec = lenleft_reg[vcnt_reg] - 16'd1;
        v_reload  = !started_reg[vcnt_reg] && (v_len_dec == 16'd0);
        v_ptr     = v_reload ? sptr_reg[vcnt_reg] : fptr_reg[vcnt_reg];
        v_ok      = v_reload ? pvalid_reg[vcnt_reg] : fvalid_reg[vcnt_reg];
        raddr     = v_ptr;
        mem_we    = pop && (q_item.op == OP_MEM);
    end

    // Current voice: byte, scaled sample, phase
    always_comb
    begin
        if (need_word_reg)
            v_word = word_ok_reg ? rdata_reg : 16'd0;
        else
            v_word = word_reg[vcnt_reg];
        v_prod   = 16'(signed'(v_word[15:8])) * signed'({9'd0, vol_reg[vcnt_reg]});
        v_sample = do_fetch_reg ? v_prod[13:0] : cur_reg[vcnt_reg];
        v_phase  = {1'b0, phase_reg[vcnt_reg]} + {1'b0, step_reg[vcnt_reg]};
        v_side   = 2'(vcnt_reg);
    end

    always_comb
    begin
        mask_now = '0;
        for (int v = 0; v < VOICE_COUNT && v < 4; v++)
            mask_now[v] = active_reg[v];
    end

    // Memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[AW'(q_item.addr)] <= q_item.data;
        rdata_reg <= mem[raddr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        vcnt_next  = vcnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && q_item.op == OP_PER)
                    state_next = ST_DIV;
                else if (pop && q_item.op == OP_TICK)
                begin
                    state_next = ST_SETUP;
                    vcnt_next  = '0;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_IDLE;
            end
            ST_SETUP:
            begin
                if (v_act)
                    state_next = ST_APPLY;
                else if (last_voice)
                    state_next = ST_DONE;
                else
                    vcnt_next = vcnt_reg + VW'(1);
            end
            ST_APPLY:
            begin
                if (last_voice)
                    state_next = ST_DONE;
                else
                begin
                    state_next = ST_SETUP;
                    vcnt_next  = vcnt_reg + VW'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vcnt_reg  <= vcnt_next;
        end
    end

    // Popped transaction
    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= q_item;
    end

    // Voice registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                active_reg[v]  <= 1'b0;
                pvalid_reg[v]  <= 1'b0;
                fvalid_reg[v]  <= 1'b0;
                sptr_reg[v]    <= '0;
                fptr_reg[v]    <= '0;
                slen_reg[v]    <= '0;
                lenleft_reg[v] <= '0;
                bytes_reg[v]   <= '0;
                started_reg[v] <= 1'b0;
                pend_reg[v]    <= 1'b0;
                word_reg[v]    <= '0;
                cur_reg[v]     <= '0;
                vol_reg[v]     <= '0;
                sstep_reg[v]   <= '0;
                step_reg[v]    <= '0;
                phase_reg[v]   <= '0;
            end
            do_fetch_reg  <= 1'b0;
            need_word_reg <= 1'b0;
            word_ok_reg   <= 1'b0;
            left_acc_reg  <= '0;
            right_acc_reg <= '0;
        end
        else
        begin
            // Register writes and DMA control
            if (pop)
            begin
                case (q_item.op)
                    OP_DMA:
                    begin
                        for (int v = 0; v < VOICE_COUNT; v++)
                        begin
                            if (q_item.data[v] && q_item.data[DMA_SET_BIT])
                            begin
                                fptr_reg[v]    <= sptr_reg[v];
                                fvalid_reg[v]  <= pvalid_reg[v];
                                lenleft_reg[v] <= slen_reg[v];
                                bytes_reg[v]   <= 2'd0;
                                started_reg[v] <= 1'b1;
                                step_reg[v]    <= sstep_reg[v];
                                pend_reg[v]    <= 1'b1;
                                phase_reg[v]   <= '0;
                                active_reg[v]  <= 1'b1;
                            end
                            else if (q_item.data[v])
                                active_reg[v] <= 1'b0;
                        end
                    end
                    OP_LEN: slen_reg[VW'(q_item.voice)] <= q_item.data;
                    OP_VOL: vol_reg[VW'(q_item.voice)]  <= q_item.data[6:0];
                    OP_PTR:
                    begin
                        sptr_reg[VW'(q_item.voice)]   <= AW'(q_item.addr);
                        pvalid_reg[VW'(q_item.voice)] <= 1'b1;
                    end
                    OP_TICK:
                    begin
                        left_acc_reg  <= '0;
                        right_acc_reg <= '0;
                    end
                    default: ;
                endcase
            end

            // Step from the divider
            if (state_reg == ST_DIV && div_done)
                sstep_reg[VW'(item_reg.voice)] <= div_q;

            // Tick, first half: word fetch bookkeeping and memory read
            if (state_reg == ST_SETUP && v_act)
            begin
                do_fetch_reg  <= pend_reg[vcnt_reg];
                need_word_reg <= v_need;
                word_ok_reg   <= v_ok;
                if (v_need)
                begin
                    if (!started_reg[vcnt_reg])
                        lenleft_reg[vcnt_reg] <= v_reload ? slen_reg[vcnt_reg] : v_len_dec;
                    started_reg[vcnt_reg] <= 1'b0;
                    fptr_reg[vcnt_reg]    <= v_ptr + AW'(1);
                    fvalid_reg[vcnt_reg]  <= v_ok;
                end
            end

            // Tick, second half: byte out, mix, phase
            if (state_reg == ST_APPLY)
            begin
                if (do_fetch_reg)
                begin
                    cur_reg[vcnt_reg]   <= v_prod[13:0];
                    word_reg[vcnt_reg]  <= {v_word[7:0], 8'd0};
                    bytes_reg[vcnt_reg] <= (need_word_reg ? 2'd2 : bytes_reg[vcnt_reg]) - 2'd1;
                end
                if (v_side == 2'd0 || v_side == 2'd3)
                    left_acc_reg  <= left_acc_reg + 18'(v_sample);
                else
                    right_acc_reg <= right_acc_reg + 18'(v_sample);
                // Any fetch is consumed here; a phase wrap arms the next one
                pend_reg[vcnt_reg] <= v_phase[32];
                if (v_phase[32])
                    step_reg[vcnt_reg] <= sstep_reg[vcnt_reg];
                phase_reg[vcnt_reg] <= v_phase[31:0];
            end
        end
    end

    function automatic logic signed [14:0] clamp15(input logic signed [17:0] x);
        if (x > 18'sd16383)
            return 15'sd16383;
        if (x < -18'sd16384)
            return -15'sd16384;
        return x[14:0];
    endfunction

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        begin
            left_out_reg  <= clamp15(left_acc_reg);
            right_out_reg <= clamp15(right_acc_reg);
            mask_out_reg  <= mask_now;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_mix    = left_out_reg;
    assign right_mix   = right_out_reg;
    assign active_mask = mask_out_reg;

endmodule

// ----- test/four_voice_sample_dma_player_tb.sv -----
`timescale 1ns / 100ps

module four_voice_sample_dma_player_tb;
    import fvsp_pkg::*;

    localparam int VOICES     = 4;
    localparam int CYCLE_CAP  = 1500000;
    localparam int DRAIN_WAIT = 300;

    typedef struct {
        logic signed [14:0] left;
        logic signed [14:0] right;
        logic [3:0]         mask;
    } mix_frame_t;

    // Scoreboard: shadow of the voice engine plus the queue of expected frames
    class mix_scoreboard;
        bit [15:0] mem [0:65535];
        bit        written [0:65535];
        bit [31:0] ratio;
        bit        active [VOICES];
        bit        ptr_ok [VOICES];
        bit        fetch_ok [VOICES];
        bit [15:0] ptr_reg [VOICES];
        bit [15:0] fetch_ptr [VOICES];
        bit [15:0] len_reg [VOICES];
        bit [15:0] len_left [VOICES];
        bit [1:0]  byte_cnt [VOICES];
        bit        fresh [VOICES];
        bit        pending [VOICES];
        bit [15:0] word [VOICES];
        int        level [VOICES];
        bit [6:0]  vol [VOICES];
        bit [31:0] step_reg [VOICES];
        bit [31:0] step [VOICES];
        bit [31:0] acc [VOICES];
        mix_frame_t frames [$];
        int errors;
        int checked;

        function new();
            ratio = RATIO_RESET;
            errors = 0;
            checked = 0;
            foreach (written[i]) written[i] = 0;
            foreach (active[v])
            begin
                active[v] = 0; ptr_ok[v] = 0; fetch_ok[v] = 0;
                ptr_reg[v] = 0; fetch_ptr[v] = 0; len_reg[v] = 0; len_left[v] = 0;
                byte_cnt[v] = 0; fresh[v] = 0; pending[v] = 0; word[v] = 0;
                level[v] = 0; vol[v] = 0; step_reg[v] = 0; step[v] = 0; acc[v] = 0;
            end
        endfunction

        // Address the next tick will read that has never been filled, or -1
        function int unfilled_addr();
            bit [15:0] a;
            bit        ok;
            for (int v = 0; v < VOICES; v++)
            begin
                if (active[v] && pending[v] && byte_cnt[v] == 0)
                begin
                    a = fetch_ptr[v];
                    ok = fetch_ok[v];
                    if (!fresh[v] && len_left[v] == 16'd1)
                    begin
                        a = ptr_reg[v];
                        ok = ptr_ok[v];
                    end
                    if (ok && !written[a])
                        return int'(a);
                end
            end
            return -1;
        endfunction

        function void next_byte(int v);
            int b;
            if (byte_cnt[v] == 0)
            begin
                if (!fresh[v])
                begin
                    len_left[v] = len_left[v] - 16'd1;
                    if (len_left[v] == 0)
                    begin
                        len_left[v] = len_reg[v];
                        fetch_ptr[v] = ptr_reg[v];
                        fetch_ok[v] = ptr_ok[v];
                    end
                end
                fresh[v] = 0;
                word[v] = fetch_ok[v] ? mem[fetch_ptr[v]] : 16'd0;
                fetch_ptr[v] = fetch_ptr[v] + 16'd1;
                byte_cnt[v] = 2;
            end
            b = int'($signed(word[v][15:8]));
            level[v] = b * int'(vol[v]);
            word[v] = {word[v][7:0], 8'd0};
            byte_cnt[v] = byte_cnt[v] - 2'd1;
        endfunction

        function logic signed [14:0] sat15(int x);
            if (x > 16383) return 15'sd16383;
            if (x < -16384) return -15'sd16384;
            return x[14:0];
        endfunction

        // Update the shadow for one accepted transaction
        function void note_input(op_t op, bit [1:0] vc, bit [15:0] d, bit [15:0] a);
            bit [16:0] per;
            bit [63:0] q;
            bit [31:0] nxt;
            int lsum, rsum;
            mix_frame_t f;
            case (op)
                OP_DMA:
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (d[v])
                        begin
                            if (d[DMA_SET_BIT])
                            begin
                                fetch_ptr[v] = ptr_reg[v]; fetch_ok[v] = ptr_ok[v];
                                len_left[v] = len_reg[v]; byte_cnt[v] = 0; fresh[v] = 1;
                                step[v] = step_reg[v]; pending[v] = 1; acc[v] = 0;
                                active[v] = 1;
                            end
                            else
                                active[v] = 0;
                        end
                    end
                OP_MEM:
                begin
                    mem[a] = d;
                    written[a] = 1;
                end
                OP_LEN: len_reg[vc] = d;
                OP_PER:
                begin
                    per = (d == 0) ? 17'd65536 : ((d < 16'd113) ? 17'd113 : {1'b0, d});
                    q = {24'd0, ratio, 8'd0} / {47'd0, per};
                    step_reg[vc] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                end
                OP_VOL: vol[vc] = (d[6:0] > 7'd64) ? 7'd64 : d[6:0];
                OP_PTR:
                begin
                    ptr_reg[vc] = a;
                    ptr_ok[vc] = 1;
                end
                OP_TICK:
                begin
                    lsum = 0;
                    rsum = 0;
                    f.mask = '0;
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (active[v])
                        begin
                            if (pending[v])
                            begin
                                pending[v] = 0;
                                next_byte(v);
                            end
                            if (v == 0 || v == 3) lsum += level[v];
                            else rsum += level[v];
                            nxt = acc[v] + step[v];
                            if (nxt < acc[v])
                            begin
                                step[v] = step_reg[v];
                                pending[v] = 1;
                            end
                            acc[v] = nxt;
                            f.mask[v] = 1'b1;
                        end
                    end
                    f.left = sat15(lsum);
                    f.right = sat15(rsum);
                    frames.push_back(f);
                end
                default: ;
            endcase
        endfunction

        // Compare one delivered frame with the oldest expected one
        function void check_frame(logic signed [14:0] l, logic signed [14:0] r,
                                  logic [3:0] m);
            mix_frame_t f;
            checked++;
            if (frames.size() == 0)
            begin
                $error("unexpected output frame l=%0d r=%0d mask=%h", l, r, m);
                errors++;
                return;
            end
            f = frames.pop_front();
            if (l !== f.left)
            begin
                $error("left_mix expected %0d got %0d", f.left, l);
                errors++;
            end
            if (r !== f.right)
            begin
                $error("right_mix expected %0d got %0d", f.right, r);
                errors++;
            end
            if (m !== f.mask)
            begin
                $error("active_mask expected %h got %h", f.mask, m);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [1:0]  voice;
    logic [15:0] data;
    logic [15:0] sample_address;
    logic        out_valid;
    logic        out_ready;
    logic signed [14:0] left_mix;
    logic signed [14:0] right_mix;
    logic [3:0]  active_mask;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    mix_scoreboard sb;
    int  cycles;
    int  tick_count;
    int  item_count;
    bit  quiet;

    four_voice_sample_dma_player dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .voice          (voice),
        .data           (data),
        .sample_address (sample_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_mix       (left_mix),
        .right_mix      (right_mix),
        .active_mask    (active_mask),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Cycle cap
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_frame(left_mix, right_mix, active_mask);
    end

    // Receiver backpressure in random bursts
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            out_ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    // One input transaction; called at a falling edge, returns at a falling edge
    task automatic push_item(op_t op, bit [1:0] vc, bit [15:0] d, bit [15:0] a);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid = 1'b1;
        action = op;
        voice = vc;
        data = d;
        sample_address = a;
        do @(posedge clk); while (!in_ready);
        sb.note_input(op, vc, d, a);
        item_count++;
        if (op == OP_TICK) tick_count++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Fill any word the coming tick is about to read, then send it
    task automatic send_item(op_t op, bit [1:0] vc, bit [15:0] d, bit [15:0] a);
        int hole;
        if (op == OP_TICK)
        begin
            hole = sb.unfilled_addr();
            while (hole >= 0)
            begin
                push_item(OP_MEM, 2'($urandom), 16'($urandom), 16'(hole));
                hole = sb.unfilled_addr();
            end
        end
        push_item(op, vc, d, a);
    endtask

    // Queued period writes need the divider; the wait covers a full queue of them
    task automatic wait_drained();
        while (sb.frames.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_ratio(bit [31:0] r);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data = r;
        do @(posedge clk); while (!cfg_ready);
        sb.ratio = r;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random transaction, biased toward playing voices
    task automatic random_item();
        int pick;
        bit [1:0] vc;
        bit [15:0] d;
        pick = $urandom_range(0, 99);
        vc = 2'($urandom);
        d = 16'($urandom);
        if (pick < 55)
            send_item(OP_TICK, vc, d, 16'($urandom));
        else if (pick < 63)
            send_item(OP_MEM, vc, d, 16'($urandom));
        else if (pick < 70)
            send_item(OP_PTR, vc, d, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 511)));
        else if (pick < 76)
            send_item(OP_LEN, vc, ($urandom_range(0, 9) == 0) ? d
                                                            : 16'($urandom_range(0, 40)),
                      16'($urandom));
        else if (pick < 82)
            send_item(OP_PER, vc, ($urandom_range(0, 4) == 0) ? d
                                                            : 16'($urandom_range(100, 500)),
                      16'($urandom));
        else if (pick < 88)
            send_item(OP_VOL, vc, d, 16'($urandom));
        else if (pick < 97)
            send_item(OP_DMA, vc, {$urandom_range(0, 2) != 0, d[14:0]}, 16'($urandom));
        else
            send_item(OP_NONE, vc, d, 16'($urandom));
    endtask

    initial
    begin
        bit [31:0] ratios [4];
        sb = new();
        cycles = 0;
        tick_count = 0;
        item_count = 0;
        quiet = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = OP_TICK;
        voice = '0;
        data = '0;
        sample_address = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, clamps, wraps, no-pointer start, unknown op
        send_item(OP_TICK, 2'd3, 16'hFFFF, 16'hFFFF);
        send_item(OP_MEM, 2'd0, 16'h7F80, 16'h0000);
        send_item(OP_MEM, 2'd0, 16'h807F, 16'hFFFF);
        send_item(OP_PTR, 2'd0, 16'h0000, 16'h0000);
        send_item(OP_PTR, 2'd3, 16'hFFFF, 16'hFFFF);
        send_item(OP_LEN, 2'd0, 16'h0000, 16'h0000);
        send_item(OP_LEN, 2'd3, 16'hFFFF, 16'h0000);
        send_item(OP_PER, 2'd0, 16'h0000, 16'h0000);
        send_item(OP_PER, 2'd3, 16'h0001, 16'h0000);
        send_item(OP_PER, 2'd1, 16'd113, 16'h0000);
        send_item(OP_PER, 2'd2, 16'hFFFF, 16'h0000);
        send_item(OP_VOL, 2'd0, 16'h007F, 16'h0000);
        send_item(OP_VOL, 2'd3, 16'hFFC0, 16'h0000);
        send_item(OP_VOL, 2'd1, 16'h0041, 16'h0000);
        send_item(OP_DMA, 2'd2, 16'h800F, 16'h0000);
        for (int i = 0; i < 6; i++) send_item(OP_TICK, 2'($urandom), 16'h0, 16'h0);
        send_item(OP_NONE, 2'd1, 16'h8001, 16'h1234);
        send_item(OP_DMA, 2'd0, 16'h0006, 16'h0000);
        send_item(OP_TICK, 2'd0, 16'h0, 16'h0);
        send_item(OP_DMA, 2'd0, 16'h000F, 16'h0000);
        send_item(OP_TICK, 2'd0, 16'h0, 16'h0);

        // Several divider settings, extremes among them
        ratios[0] = RATIO_RESET;
        ratios[1] = 32'hFFFF_FFFF;
        ratios[2] = 32'h0000_0000;
        ratios[3] = $urandom;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_ratio(ratios[ph]);
            for (int v = 0; v < VOICES; v++)
                send_item(OP_PER, 2'(v), 16'($urandom_range(113, 400)), 16'h0);
            for (int i = 0; i < 400; i++)
            begin
                if (ph == 1 && i == 200)
                    wait_drained();
                if (ph == 3 && i == 200)
                    quiet = 1;
                random_item();
            end
        end

        wait_drained();
        if (sb.frames.size() != 0)
        begin
            $error("%0d expected frames never arrived", sb.frames.size());
            sb.errors++;
        end
        $display("Sent %0d transactions including %0d ticks; %0d frames checked.",
                 item_count, tick_count, sb.checked);
        $display("Four ratio settings, clamped periods and volumes, DMA start/stop, wraps.");
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
